@@ hdl/pwlg_pkg.sv @@
// Shared types, codes and the quarter-wave sine constant builder for the waveform generator.
package pwlg_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned WaveBits   = 3;

  localparam logic [63:0] PiHalfQ30   = 64'd1686629713;
  localparam logic [63:0] TaylorDiv1  = 64'd6;
  localparam logic [63:0] TaylorDiv2  = 64'd20;
  localparam logic [63:0] TaylorDiv3  = 64'd42;
  localparam logic [63:0] TaylorDiv4  = 64'd72;
  localparam logic [63:0] TaylorDiv5  = 64'd110;
  localparam logic [63:0] TaylorDiv6  = 64'd156;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_START_LEVEL = 3'd0,
    CFG_END_LEVEL   = 3'd1,
    CFG_PERIOD      = 3'd2,
    CFG_WAVEFORM    = 3'd3,
    CFG_ENABLE      = 3'd4
  } cfg_idx_e;

  typedef enum logic [WaveBits-1:0] {
    WAVE_TRIANGLE = 3'd0,
    WAVE_SINE     = 3'd1,
    WAVE_COSINE   = 3'd2,
    WAVE_SAWTOOTH = 3'd3,
    WAVE_SQUARE   = 3'd4
  } wave_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROM,
    ST_WGT,
    ST_MUL,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rom_rd;
    logic wgt_load;
    logic mul_step;
    logic finish;
  } pwlg_cmd_t;

  typedef struct packed {
    logic                enable;
    logic [WaveBits-1:0] wave;
    logic                cnt_last;
    logic                out_free;
  } pwlg_sts_t;

  // quarter-wave sine entry in Q16, Taylor series in Q30 through the x^13 term
  function automatic logic [15:0] sine_entry(int unsigned idx, int unsigned bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] e;
    longint      acc;
    x    = (PiHalfQ30 * 64'(idx)) >> bits;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      unique case (k)
        1: term = term / TaylorDiv1;
        2: term = term / TaylorDiv2;
        3: term = term / TaylorDiv3;
        4: term = term / TaylorDiv4;
        5: term = term / TaylorDiv5;
        default: term = term / TaylorDiv6;
      endcase
      if ((k % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    e = ((64'(acc) * 64'd65536) + (64'd1 << 29)) >> 30;
    if (e > 64'd65535) begin
      e = 64'd65535;
    end
    return e[15:0];
  endfunction

endpackage

@@ hdl/pwlg_ctrl.sv @@
// Sequencer for one item: accept, divide, table read (sine and cosine only), weight, multiply, result.
module pwlg_ctrl import pwlg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pwlg_sts_t sts_i,
  output pwlg_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.enable ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_last) begin
          priority if (sts_i.wave == WAVE_SINE || sts_i.wave == WAVE_COSINE) begin
            state_d = ST_ROM;
          end else if (sts_i.wave == WAVE_TRIANGLE || sts_i.wave == WAVE_SAWTOOTH) begin
            state_d = ST_WGT;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_ROM: begin
        cmd_o.rom_rd = 1'b1;
        state_d      = ST_WGT;
      end
      ST_WGT: begin
        cmd_o.wgt_load = 1'b1;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/pwlg_dp.sv @@
// Datapath: registers, phase divider, sine table, serial multiplier and output register.
module pwlg_dp import pwlg_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS     = 10,
  parameter int unsigned PHASE_FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [DataWidth-1:0]  cfg_data_i,
  input  logic [DataWidth-1:0]  elapsed_i,
  input  pwlg_cmd_t             cmd_i,
  output pwlg_sts_t             sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DataWidth-1:0]  level_o,
  output logic                  wrapped_o
);

  localparam int unsigned Fb        = PHASE_FRACTION_BITS;
  localparam int unsigned Stb       = SINE_TABLE_BITS;
  localparam int unsigned TableSize = 1 << Stb;
  localparam int unsigned Ww        = ((Fb > 16) ? Fb : 16) + 1;
  localparam int unsigned Pw        = DataWidth + 1 + Ww;
  localparam int unsigned Cw        = $clog2(Ww);
  localparam int unsigned Iw        = Fb + 1 + Stb + 2;

  // configuration
  logic signed [DataWidth-1:0] start_q, end_q;
  logic [DataWidth-1:0]        period_q;
  logic [WaveBits-1:0]         wave_q;
  logic                        enable_q;

  // state
  logic [DataWidth-1:0] phase_q;
  logic                 rising_q;
  logic [DataWidth-1:0] held_q, held_d;

  // per-item work registers
  logic [DataWidth-1:0] phase_nx_q;
  logic                 full_q;
  logic [DataWidth-1:0] rem_q;
  logic [Fb:0]          quo_q;
  logic [Cw-1:0]        cnt_q;
  logic [15:0]          rom_q;
  logic [1:0]           quad_q;
  logic                 rzero_q;
  logic [Ww-1:0]        w_q;
  logic signed [Pw-1:0] acc_q;
  logic                 out_valid_q;
  logic [DataWidth-1:0] level_q;
  logic                 wrapped_q;

  logic [DataWidth-1:0] p_eff;
  logic [DataWidth:0]   sum;
  logic                 sum_full;
  logic [DataWidth:0]   rem2;
  logic                 rem_ge;
  logic [Iw-1:0]        f_sc;
  logic [Stb+1:0]       idx;
  logic [Stb-1:0]       rom_addr;
  logic [15:0]          rom_c [TableSize];
  logic [16:0]          sine_mag;
  logic [17:0]          sine_w2;
  logic [Ww-1:0]        w_load;
  logic signed [DataWidth:0] step;
  logic signed [Pw-1:0] step_ext;
  logic signed [Pw-1:0] sh_ramp_full, sh_sine_full;
  logic [DataWidth-1:0] sh_ramp, sh_sine;
  logic                 out_free;

  for (genvar g = 0; g < TableSize; g++) begin : g_rom
    localparam logic [15:0] Entry = sine_entry(g, Stb);
    assign rom_c[g] = Entry;
  end

  assign p_eff    = (period_q == '0) ? DataWidth'(1) : period_q;
  assign sum      = {1'b0, phase_q} + {1'b0, elapsed_i};
  assign sum_full = (sum >= {1'b0, p_eff});
  assign rem2     = {rem_q, 1'b0};
  assign rem_ge   = (rem2 >= {1'b0, p_eff});

  assign f_sc = {quo_q, {(Stb + 2){1'b0}}} >> Fb;
  assign idx  = f_sc[Stb+1:0] + ((wave_q == WAVE_COSINE) ? {2'b01, {Stb{1'b0}}} : '0);
  assign rom_addr = idx[Stb] ? (Stb'(0) - idx[Stb-1:0]) : idx[Stb-1:0];

  assign sine_mag = (quad_q[0] && rzero_q) ? 17'h10000 : {1'b0, rom_q};
  assign sine_w2  = quad_q[1] ? (18'h10000 - {1'b0, sine_mag})
                              : (18'h10000 + {1'b0, sine_mag});

  always_comb begin
    if (wave_q == WAVE_SINE || wave_q == WAVE_COSINE) begin
      w_load = Ww'(sine_w2[17:1]);
    end else begin
      w_load = Ww'(quo_q);
    end
  end

  assign step     = {end_q[DataWidth-1], end_q} - {start_q[DataWidth-1], start_q};
  assign step_ext = Pw'(step);

  assign sh_ramp_full = acc_q >>> Fb;
  assign sh_sine_full = acc_q >>> 16;
  assign sh_ramp      = sh_ramp_full[DataWidth-1:0];
  assign sh_sine      = sh_sine_full[DataWidth-1:0];

  always_comb begin
    held_d = held_q;
    if (enable_q) begin
      unique case (wave_q)
        WAVE_TRIANGLE: held_d = rising_q ? (start_q + sh_ramp) : (end_q - sh_ramp);
        WAVE_SINE,
        WAVE_COSINE:   held_d = start_q + sh_sine;
        WAVE_SAWTOOTH: held_d = start_q + sh_ramp;
        WAVE_SQUARE:   held_d = rising_q ? start_q : end_q;
        default:       held_d = held_q;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      end_q       <= '0;
      period_q    <= DataWidth'(1);
      wave_q      <= WAVE_TRIANGLE;
      enable_q    <= 1'b0;
      phase_q     <= '0;
      rising_q    <= 1'b1;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_START_LEVEL: start_q <= cfg_data_i;
          CFG_END_LEVEL:   end_q   <= cfg_data_i;
          CFG_PERIOD: begin
            if (cfg_data_i != period_q) begin
              period_q <= cfg_data_i;
              phase_q  <= '0;
              rising_q <= 1'b1;
              held_q   <= start_q;
            end
          end
          CFG_WAVEFORM:    wave_q   <= cfg_data_i[WaveBits-1:0];
          CFG_ENABLE:      enable_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        cnt_q <= Cw'(Fb - 1);
      end else if (cmd_i.wgt_load) begin
        cnt_q <= Cw'(Ww - 1);
      end else if (cmd_i.div_step || cmd_i.mul_step) begin
        cnt_q <= cnt_q - Cw'(1);
      end
      if (cmd_i.finish) begin
        held_q      <= held_d;
        out_valid_q <= 1'b1;
        if (enable_q) begin
          phase_q <= phase_nx_q;
          if (full_q) begin
            rising_q <= ~rising_q;
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      full_q     <= sum_full;
      phase_nx_q <= sum_full ? '0 : sum[DataWidth-1:0];
      rem_q      <= sum_full ? '0 : sum[DataWidth-1:0];
      quo_q      <= {{Fb{1'b0}}, sum_full};
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? DataWidth'(rem2 - {1'b0, p_eff}) : rem2[DataWidth-1:0];
      quo_q <= {quo_q[Fb-1:0], rem_ge};
    end
    if (cmd_i.rom_rd) begin
      rom_q   <= rom_c[rom_addr];
      quad_q  <= idx[Stb+1:Stb];
      rzero_q <= (idx[Stb-1:0] == '0);
    end
    if (cmd_i.wgt_load) begin
      w_q   <= w_load;
      acc_q <= '0;
    end
    if (cmd_i.mul_step) begin
      acc_q <= (acc_q <<< 1) + (w_q[Ww-1] ? step_ext : '0);
      w_q   <= {w_q[Ww-2:0], 1'b0};
    end
    if (cmd_i.finish) begin
      level_q   <= held_d;
      wrapped_q <= enable_q & full_q;
    end
  end

  assign sts_o.enable   = enable_q;
  assign sts_o.wave     = wave_q;
  assign sts_o.cnt_last = (cnt_q == '0);
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign wrapped_o   = wrapped_q;

endmodule

@@ hdl/periodic_waveform_level_generator.sv @@
// Top level of the periodic waveform level generator.
//
//   channel   | dir | handshake                    | payload
//   s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata[31:0] elapsed
//   m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata[31:0] level, tlast wrapped
//   cfg       | in  | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
// Enabled item: accept, divider steps, table read (sine and cosine only), weight load,
// multiplier steps, result. The shift-subtract divider (one quotient bit a cycle) and the
// shift-add multiplier (one weight bit a cycle) set its length. Square and unused codes
// skip table read, weight and multiply; disabled items go straight from accept to result.
// One item is in work at a time; the result register lets the next item in while the
// previous result waits. Reset clears config, phase and output valid; no clearing pass.
module periodic_waveform_level_generator import pwlg_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS     = 10,
  parameter int unsigned PHASE_FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [DataWidth-1:0]  cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DataWidth-1:0]  s_axis_tdata,  // [31:0] elapsed
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DataWidth-1:0]  m_axis_tdata,  // [31:0] level
  output logic                  m_axis_tlast
);

  pwlg_cmd_t cmd;
  pwlg_sts_t sts;

  pwlg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pwlg_dp #(
    .SINE_TABLE_BITS     (SINE_TABLE_BITS),
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .elapsed_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .level_o     (m_axis_tdata),
    .wrapped_o   (m_axis_tlast)
  );

endmodule

@@ sim/periodic_waveform_level_generator_tb.sv @@
// Self-checking testbench for the periodic waveform level generator: ticks in, levels checked.
module periodic_waveform_level_generator_tb import pwlg_pkg::*;;

  localparam int unsigned TableBits   = 10;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned TableSize   = 1 << TableBits;
  localparam int unsigned ClkHalf     = 5;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StallCycles = 300;
  localparam int unsigned RandomTicks = 700;
  localparam logic [63:0] HalfPiQ30   = 64'd1686629713;

  localparam logic [WaveBits-1:0] WaveUnusedLow = 3'd5;
  localparam logic [WaveBits-1:0] WaveUnusedTop = 3'd7;

  typedef struct packed {
    logic [DataWidth-1:0] level;
    logic                 wrapped;
  } level_item_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i     = CFG_START_LEVEL;
  logic [DataWidth-1:0]  cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DataWidth-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DataWidth-1:0]  m_axis_tdata;
  logic                  m_axis_tlast;

  // predictor copy of the registers and the phase state
  logic [DataWidth-1:0] osc_start  = '0;
  logic [DataWidth-1:0] osc_end    = '0;
  logic [DataWidth-1:0] osc_period = 32'd1;
  logic [WaveBits-1:0]  osc_wave   = WAVE_TRIANGLE;
  logic                 osc_enable = 1'b0;
  logic [DataWidth-1:0] phase_time = '0;
  logic                 rising     = 1'b1;
  logic [DataWidth-1:0] held_level = '0;
  logic [15:0]          sine_quarter [TableSize];

  level_item_t level_q [$];
  level_item_t rx_expected;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  bit          stall_request  = 1'b0;
  logic        rx_hold        = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned ticks_sent     = 0;
  int unsigned levels_checked = 0;
  int unsigned wraps_seen     = 0;

  periodic_waveform_level_generator #(
    .SINE_TABLE_BITS    (TableBits),
    .PHASE_FRACTION_BITS(FracBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #ClkHalf clk_i = ~clk_i;

  function automatic void fill_sine_quarter();
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] q16;
    longint      acc;
    for (int i = 0; i < TableSize; i++) begin
      x    = (HalfPiQ30 * 64'(i)) >> TableBits;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) begin
        acc = 0;
      end
      q16 = (64'(acc) * 64'd65536 + (64'd1 << 29)) >> 30;
      sine_quarter[i] = (q16 > 64'd65535) ? 16'hFFFF : q16[15:0];
    end
  endfunction

  // advance the phase by one tick and return the level the block must give
  function automatic level_item_t advance_oscillator(logic [DataWidth-1:0] elapsed);
    level_item_t r;
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] f;
    logic [63:0] idx_wide;
    logic [11:0] idx;
    longint      s0;
    longint      s1;
    longint      step;
    longint      sv;
    longint      w;
    r.wrapped = 1'b0;
    if (osc_enable) begin
      p    = (osc_period == '0) ? 64'd1 : 64'(osc_period);
      t    = 64'(phase_time) + 64'(elapsed);
      s0   = longint'($signed(osc_start));
      s1   = longint'($signed(osc_end));
      step = s1 - s0;
      if (t >= p) begin
        t = p;
      end
      f = (t << FracBits) / p;
      case (osc_wave)
        WAVE_TRIANGLE: begin
          if (rising) begin
            held_level = 32'(s0 + ((step * longint'(f)) >>> FracBits));
          end else begin
            held_level = 32'(s1 - ((step * longint'(f)) >>> FracBits));
          end
        end
        WAVE_SINE, WAVE_COSINE: begin
          idx_wide = (f << (TableBits + 2)) >> FracBits;
          idx = idx_wide[11:0] + ((osc_wave == WAVE_COSINE) ? 12'(TableSize) : 12'd0);
          if (!idx[10]) begin
            sv = longint'(sine_quarter[idx[9:0]]);
          end else begin
            sv = (idx[9:0] == '0) ? longint'(65536)
                 : longint'(sine_quarter[TableBits'(TableSize - int'(idx[9:0]))]);
          end
          if (idx[11]) begin
            sv = -sv;
          end
          w = (sv + 65536) >>> 1;
          held_level = 32'(s0 + ((step * w) >>> 16));
        end
        WAVE_SAWTOOTH: held_level = 32'(s0 + ((step * longint'(f)) >>> FracBits));
        WAVE_SQUARE:   held_level = rising ? osc_start : osc_end;
        default: ;
      endcase
      if (t == p) begin
        t         = '0;
        rising    = ~rising;
        r.wrapped = 1'b1;
      end
      phase_time = t[31:0];
    end
    r.level = held_level;
    return r;
  endfunction

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (level_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DataWidth-1:0] val);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START_LEVEL: osc_start = val;
      CFG_END_LEVEL:   osc_end = val;
      CFG_PERIOD: begin
        if (val != osc_period) begin
          osc_period = val;
          phase_time = '0;
          rising     = 1'b1;
          held_level = osc_start;
        end
      end
      CFG_WAVEFORM: osc_wave = val[WaveBits-1:0];
      CFG_ENABLE:   osc_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic send_tick(input logic [DataWidth-1:0] elapsed);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= elapsed;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    level_q.push_back(advance_oscillator(elapsed));
    ticks_sent++;
  endtask

  // check each level against the oldest prediction
  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (level_q.size() == 0) begin
        $error("level %h arrived with no tick pending", m_axis_tdata);
        mismatch_count++;
      end else begin
        rx_expected = level_q.pop_front();
        if (m_axis_tdata !== rx_expected.level) begin
          $error("level: expected %h, got %h", rx_expected.level, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tlast !== rx_expected.wrapped) begin
          $error("wrapped: expected %b, got %b", rx_expected.wrapped, m_axis_tlast);
          mismatch_count++;
        end
        levels_checked++;
        if (rx_expected.wrapped) begin
          wraps_seen++;
        end
      end
    end
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // hold off the output for a long stretch on request
  initial begin
    forever begin
      wait (stall_request);
      rx_hold <= 1'b1;
      repeat (StallCycles) @(posedge clk_i);
      rx_hold <= 1'b0;
      stall_request = 1'b0;
    end
  end

  task automatic test_reset_defaults();
    send_tick(32'h0000_0000);
    send_tick(32'hFFFF_FFFF);
  endtask

  task automatic test_waveform_extremes();
    write_reg(CFG_START_LEVEL, 32'h8000_0000);
    write_reg(CFG_END_LEVEL, 32'h7FFF_FFFF);
    write_reg(CFG_PERIOD, 32'd4);
    write_reg(CFG_ENABLE, 32'd1);
    send_tick(32'd2);
    send_tick(32'd5);
    send_tick(32'd1);
    write_reg(CFG_WAVEFORM, DataWidth'(WAVE_SINE));
    send_tick(32'd1);
    send_tick(32'd3);
    write_reg(CFG_WAVEFORM, DataWidth'(WAVE_COSINE));
    send_tick(32'd0);
    send_tick(32'hFFFF_FFFF);
    write_reg(CFG_WAVEFORM, DataWidth'(WAVE_SAWTOOTH));
    send_tick(32'd3);
    send_tick(32'd1);
    write_reg(CFG_WAVEFORM, DataWidth'(WAVE_SQUARE));
    send_tick(32'd1);
    send_tick(32'd3);
    write_reg(CFG_WAVEFORM, DataWidth'(WaveUnusedTop));
    send_tick(32'd4);
  endtask

  task automatic test_period_corners();
    write_reg(CFG_WAVEFORM, DataWidth'(WAVE_TRIANGLE));
    write_reg(CFG_PERIOD, 32'd0);
    send_tick(32'd0);
    send_tick(32'd1);
    write_reg(CFG_PERIOD, 32'hFFFF_FFFF);
    send_tick(32'h7FFF_FFFF);
    send_tick(32'hFFFF_FFFF);
    write_reg(CFG_PERIOD, 32'hFFFF_FFFF);
    send_tick(32'd1);
  endtask

  task automatic test_hold_and_limits();
    write_reg(CFG_START_LEVEL, 32'h7FFF_FFFF);
    write_reg(CFG_END_LEVEL, 32'h8000_0000);
    write_reg(CFG_ENABLE, 32'd0);
    send_tick(32'hFFFF_FFFF);
    write_reg(CFG_ENABLE, 32'd1);
    write_reg(CFG_WAVEFORM, DataWidth'(WAVE_SAWTOOTH));
    send_tick(32'h4000_0000);
  endtask

  task automatic test_output_stall();
    write_reg(CFG_PERIOD, 32'd10);
    write_reg(CFG_WAVEFORM, DataWidth'(WAVE_TRIANGLE));
    stall_request = 1'b1;
    repeat (16) send_tick($urandom_range(6));
  endtask

  task automatic test_random_sweep(input int unsigned n_ticks);
    int unsigned          sent;
    int unsigned          seg;
    logic [DataWidth-1:0] pe;
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    logic [DataWidth-1:0] elapsed;
    sent = 0;
    while (sent < n_ticks) begin
      if ($urandom_range(99) < 60) begin
        case ($urandom_range(3))
          0: begin a = $urandom; b = $urandom; end
          1: begin
            a = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            b = ~a;
          end
          2: begin a = $urandom; b = a; end
          default: begin
            a = 32'($urandom_range(2097152)) - 32'd1048576;
            b = 32'($urandom_range(2097152)) - 32'd1048576;
          end
        endcase
        write_reg(CFG_START_LEVEL, a);
        write_reg(CFG_END_LEVEL, b);
      end
      if ($urandom_range(99) < 50) begin
        case ($urandom_range(9))
          0:       a = 32'd0;
          1:       a = 32'd1;
          2:       a = 32'hFFFF_FFFF;
          3, 4:    a = $urandom_range(16, 2);
          5, 6:    a = $urandom_range(1000, 17);
          7:       a = $urandom_range(32'h0010_0000, 1000);
          8:       a = osc_period;
          default: a = $urandom;
        endcase
        write_reg(CFG_PERIOD, a);
      end
      if ($urandom_range(99) < 50) begin
        if ($urandom_range(7) == 0) begin
          a = $urandom_range(WaveUnusedTop, WaveUnusedLow);
        end else begin
          a = $urandom_range(WAVE_SQUARE, WAVE_TRIANGLE);
        end
        if ($urandom_range(3) == 0) begin
          a[31:WaveBits] = (DataWidth - WaveBits)'($urandom);
        end
        write_reg(CFG_WAVEFORM, a);
      end
      if ($urandom_range(99) < 30) begin
        a = {$urandom_range(3) == 0 ? 31'($urandom) : 31'd0, $urandom_range(99) < 85};
        write_reg(CFG_ENABLE, a);
      end
      seg = $urandom_range(40, 8);
      repeat (seg) begin
        pe = (osc_period == '0) ? 32'd1 : osc_period;
        case ($urandom_range(9))
          0:       elapsed = 32'd0;
          1:       elapsed = pe;
          2:       elapsed = 32'hFFFF_FFFF;
          3:       elapsed = $urandom;
          4:       elapsed = pe - phase_time;
          default: elapsed = $urandom_range(pe / 4 + 1);
        endcase
        send_tick(elapsed);
      end
      sent += seg;
    end
  endtask

  initial begin
    fill_sine_quarter();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_waveform_extremes();
    test_period_corners();
    test_hold_and_limits();
    test_output_stall();
    send_idle_pct = 16;
    recv_idle_pct = 84;
    test_random_sweep(RandomTicks / 3);
    send_idle_pct = 84;
    recv_idle_pct = 16;
    test_random_sweep(RandomTicks / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sweep(RandomTicks - 2 * (RandomTicks / 3));
    wait_idle();
    $display("Run covered %0d ticks and %0d checked levels, %0d of them wrapping,",
             ticks_sent, levels_checked, wraps_seen);
    $display("over all waveform codes, zero and full-scale periods, holds and an output stall.");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
